### hdl/sequence_indexed_frame_ring_unit_assert.svh
// Assertion macros shared by the frame ring modules.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef SEQUENCE_INDEXED_FRAME_RING_UNIT_ASSERT_SVH
`define SEQUENCE_INDEXED_FRAME_RING_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SIFR_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("frame ring assertion failed");

// Next-cycle implication.
`define SIFR_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("frame ring assertion failed");

`endif

### hdl/sifr_pkg.sv
// Shared types and constants for the sequence indexed frame ring.
// No dependencies.
package sifr_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int EFF_W     = $clog2(MAX_SLOTS + 1);
  localparam int FRAME_W   = 31;
  localparam int PAYLOAD_W = 64;
  localparam int CAP_W     = 7;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = $clog2(FRAME_W);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_LATEST = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic accept;
    logic access;
    logic compare;
  } cmd_t;

  typedef struct packed {
    logic req_clear;
    logic div_done;
  } status_t;

endpackage

### hdl/sifr_div.sv
// Bit-serial restoring divider giving the slot index (frame number modulo capacity).
// Depends on sifr_pkg.
module sifr_div
  import sifr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [FRAME_W-1:0] dividend,
  input  logic [EFF_W-1:0]   divisor,
  output logic               done,
  output logic [SLOT_W-1:0]  remainder
);

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [FRAME_W-1:0] dvd;
  logic [EFF_W-1:0]   rem;
  logic [EFF_W-1:0]   trial;

  assign trial     = {rem[EFF_W-2:0], dvd[FRAME_W-1]};
  assign remainder = rem[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(FRAME_W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[FRAME_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem <= trial - divisor;
      end else begin
        rem <= trial;
      end
    end
  end

endmodule

### hdl/sifr_dp.sv
// Datapath: window registers, slot store, valid bits, capacity and result registers.
// Depends on sifr_pkg, sifr_div and the assertion macro header.
`include "sequence_indexed_frame_ring_unit_assert.svh"
module sifr_dp
  import sifr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [FRAME_W-1:0]   in_frame,
  input  logic [PAYLOAD_W-1:0] in_payload,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_data,
  output logic                 hit,
  output logic [PAYLOAD_W-1:0] payload_out,
  output logic [FRAME_W-1:0]   window_size,
  output logic [FRAME_W-1:0]   newest_frame,
  output logic [FRAME_W-1:0]   oldest_frame,
  output logic                 is_empty
);

  mode_t                mode;
  logic [FRAME_W-1:0]   key;
  logic [PAYLOAD_W-1:0] word;
  logic [CAP_W-1:0]     live_cap;
  logic [FRAME_W-1:0]   window_low;
  logic [FRAME_W-1:0]   window_high;
  logic                 empty_flag;
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [PAYLOAD_W-1:0] payload_store [MAX_SLOTS];
  logic [FRAME_W-1:0]   tag_store [MAX_SLOTS];
  logic [PAYLOAD_W-1:0] rd_payload;
  logic [FRAME_W-1:0]   rd_tag;
  logic [EFF_W-1:0]     eff_cap;
  logic [SLOT_W-1:0]    idx;
  logic                 div_done;
  logic                 div_start;
  logic [FRAME_W:0]     slide_sum;
  logic [FRAME_W-1:0]   slide_low;
  logic                 ins_active;
  logic                 ins_write;
  logic                 lk_hit;
  logic                 cfg_clear;
  mode_t                in_mode_t;

  assign in_mode_t = mode_t'(in_mode);

  always_comb begin
    if (int'(live_cap) > MAX_SLOTS) begin
      eff_cap = EFF_W'(MAX_SLOTS);
    end else begin
      eff_cap = EFF_W'(live_cap);
    end
  end

  assign div_start     = cmd.accept && (in_mode_t != MODE_CLEAR);
  assign sts.req_clear = (in_mode_t == MODE_CLEAR);
  assign sts.div_done  = div_done;
  assign cfg_clear     = cfg_we && (cfg_data != live_cap);

  sifr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  ((in_mode_t == MODE_LATEST) ? window_high : in_frame),
    .divisor   (eff_cap),
    .done      (div_done),
    .remainder (idx)
  );

  assign slide_sum  = {1'b0, key} + (FRAME_W + 1)'(1);
  assign slide_low  = (slide_sum >= (FRAME_W + 1)'(eff_cap))
                      ? FRAME_W'(slide_sum - (FRAME_W + 1)'(eff_cap)) : '0;
  assign ins_active = cmd.access && (mode == MODE_INSERT) && (eff_cap != '0);
  assign ins_write  = ins_active && (empty_flag || key >= window_low);

  assign lk_hit = ((mode == MODE_LOOKUP) || (mode == MODE_LATEST)) && !empty_flag
                  && (eff_cap != '0) && (key >= window_low) && (key <= window_high)
                  && slot_valid[idx] && (rd_tag == key);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode <= in_mode_t;
      key  <= (in_mode_t == MODE_LATEST) ? window_high : in_frame;
      word <= in_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_cap    <= CAP_RESET;
      window_low  <= '0;
      window_high <= '0;
      empty_flag  <= 1'b1;
      slot_valid  <= '0;
    end else if (cfg_clear) begin
      live_cap    <= cfg_data;
      window_low  <= '0;
      window_high <= '0;
      empty_flag  <= 1'b1;
      slot_valid  <= '0;
    end else if (cmd.accept && sts.req_clear) begin
      window_low  <= '0;
      window_high <= '0;
      empty_flag  <= 1'b1;
      slot_valid  <= '0;
    end else if (ins_active) begin
      if (empty_flag) begin
        window_low  <= key;
        window_high <= key;
        empty_flag  <= 1'b0;
      end else if (key > window_high) begin
        window_high <= key;
        window_low  <= slide_low;
      end
      if (ins_write) begin
        slot_valid[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_write) begin
      payload_store[idx] <= word;
      tag_store[idx]     <= key;
    end
    if (cmd.access) begin
      rd_payload <= payload_store[idx];
      rd_tag     <= tag_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit         <= 1'b0;
      payload_out <= '0;
    end else if (cmd.accept) begin
      hit         <= 1'b0;
      payload_out <= '0;
    end else if (cmd.compare) begin
      hit         <= lk_hit;
      payload_out <= lk_hit ? rd_payload : '0;
    end
  end

  assign window_size  = empty_flag ? '0 : (window_high - window_low + FRAME_W'(1));
  assign newest_frame = empty_flag ? '0 : window_high;
  assign oldest_frame = empty_flag ? '0 : window_low;
  assign is_empty     = empty_flag;

  `SIFR_ASSERT_IMP(a_empty_window_zero, empty_flag, window_low == '0 && window_high == '0)
  `SIFR_ASSERT_IMP(a_window_ordered, !empty_flag, window_low <= window_high)
  `SIFR_ASSERT_IMP(a_insert_no_hit, cmd.compare && mode == MODE_INSERT, !lk_hit)

endmodule

### hdl/sifr_ctrl.sv
// Controller state machine: request handshakes and sequencing of the datapath.
// Depends on sifr_pkg and the assertion macro header.
`include "sequence_indexed_frame_ring_unit_assert.svh"
module sifr_ctrl
  import sifr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DIVIDE  = 5'b00010,
    ST_ACCESS  = 5'b00100,
    ST_COMPARE = 5'b01000,
    ST_RESULT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = (state == ST_RESULT);
  assign cmd.accept  = s_tvalid && s_tready;
  assign cmd.access  = (state == ST_ACCESS);
  assign cmd.compare = (state == ST_COMPARE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sts.req_clear ? ST_RESULT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS:  state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_RESULT;
      ST_RESULT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SIFR_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
  `SIFR_ASSERT_NXT(a_clear_result, cmd.accept && sts.req_clear, m_tvalid)
  `SIFR_ASSERT_NXT(a_work_no_result, cmd.accept && !sts.req_clear, !m_tvalid)

endmodule

### hdl/sequence_indexed_frame_ring_unit.sv
// Sequence indexed frame ring: stores 64-bit packet words in a ring of slots
// indexed by frame number modulo the live capacity, with a sliding frame window.
// Usage: one request enters on s_* (s_tuser = mode, s_tdata = frame and payload);
// one result leaves on m_* for each request. Insert, lookup and latest requests
// go from acceptance to result in order through the bit-serial modulo of the
// frame number by the capacity, the remainder handover, one slot access and one
// tag compare. A clear request gives its result in the cycle after acceptance.
// With m_tready high the controller goes from the result state back to idle,
// where the next request can be taken. One request is in flight at a time;
// s_tready is high only while idle, so a stalled m_tready holds the result and
// blocks the next request.
// cfg_we with cfg_data writes the live capacity (0 disables inserts, values above
// 64 act as 64); a value different from the current one clears the window and
// all slots at once. Write it only while the block is idle.
// Reset (rst, synchronous) sets capacity 64, an empty window and all slots invalid;
// slot contents are not cleared, only invalidated.
module sequence_indexed_frame_ring_unit
  import sifr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // frame_number[30:0], payload[94:31], zero fill
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // payload_out[63:0], window_size[94:64],
                                  // newest_frame[125:95], oldest_frame[156:126]
  output logic [1:0]   m_tuser,   // hit[0], is_empty[1]
  input  logic         cfg_we,
  input  logic [6:0]   cfg_data   // live_capacity
);

  cmd_t                 cmd;
  status_t              sts;
  logic                 hit;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [FRAME_W-1:0]   window_size;
  logic [FRAME_W-1:0]   newest_frame;
  logic [FRAME_W-1:0]   oldest_frame;
  logic                 is_empty;

  sifr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sifr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (s_tuser),
    .in_frame     (s_tdata[30:0]),
    .in_payload   (s_tdata[94:31]),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .hit          (hit),
    .payload_out  (payload_out),
    .window_size  (window_size),
    .newest_frame (newest_frame),
    .oldest_frame (oldest_frame),
    .is_empty     (is_empty)
  );

  assign m_tdata = {3'b000, oldest_frame, newest_frame, window_size, payload_out};
  assign m_tuser = {is_empty, hit};

endmodule
